[design/dslp_pkg.sv]
// Package for the digit-sum linear-probe key table.
// Holds shared constants, state and status codes, and control structs.
// No dependencies.
package dslp_pkg;

   localparam int TABLE_SIZE_DEF = 10;
   localparam int KEY_W          = 32;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_FOUND    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4,
      ST_ZERO     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HOME_MUL,
      S_HOME_ACC,
      S_PROBE_RD,
      S_PROBE_CMP,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic acc;
   } dctl_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } tctl_type;

endpackage

[design/digit_sum_linear_probe_table_top.sv]
// Top level of the digit-sum linear-probe key table: sequencer and result register.
// Instantiates dslp_digit_unit and dslp_table; depends on dslp_pkg.
//
//  channel  dir  signals                      contents
//  req      in   req_tvalid/tready/tdata/tuser key, cmd (0 insert, 1 search)
//  rsp      out  rsp_tvalid/tready/tdata/tuser slot, status
//
// Per word: accept in S_IDLE; S_HOME_MUL, S_HOME_ACC per base-TABLE_SIZE digit of |key|
// (shared reciprocal multiplier); S_PROBE_RD, S_PROBE_CMP per slot (registered table read).
// Zero keys skip to S_RESP. One word in flight; req_tready is low until the result is taken.
// Reset is synchronous and empties the table at once through per-slot valid bits.
// The result holds in rsp_tdata/rsp_tuser while rsp_tready is low.
module digit_sum_linear_probe_table_top
   import dslp_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic [0:0]  req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] slot, [7:4] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   localparam int SlotW = $clog2(TABLE_SIZE);
   localparam logic [SlotW-1:0] LastSlot = SlotW'(TABLE_SIZE - 1);

   state_type        state_ff, state_in;
   logic             cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [SlotW-1:0] cnt_ff, cnt_in;
   status_type       status_ff, status_in;
   logic [SlotW-1:0] rslot_ff, rslot_in;

   dctl_type         dctl;
   tctl_type         tctl;
   logic [KEY_W-1:0] mag;
   logic             dig_last;
   logic [SlotW-1:0] home;
   logic [KEY_W-1:0] rd_key;
   logic             req_acc;
   logic             key_zero;
   logic             hit_empty;
   logic             hit_key;
   logic             resolved;
   logic [SlotW+3:0] rslot_ext;

   assign req_acc   = req_tvalid && req_tready;
   assign key_zero  = (req_tdata == '0);
   assign mag       = req_tdata[31] ? (~req_tdata + 32'd1) : req_tdata;
   assign hit_empty = (rd_key == '0);
   assign hit_key   = (rd_key == key_ff);
   assign resolved  = hit_empty || hit_key || (cnt_ff == LastSlot);

   dslp_digit_unit #(.TABLE_SIZE(TABLE_SIZE), .SlotW(SlotW)) u_digit (
      .clock (clock),
      .ctl   (dctl),
      .mag   (mag),
      .last  (dig_last),
      .home  (home)
   );

   dslp_table #(.TABLE_SIZE(TABLE_SIZE), .SlotW(SlotW)) u_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tctl),
      .addr    (slot_ff),
      .wr_data (key_ff),
      .rd_data (rd_key)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               state_in = key_zero ? S_RESP : S_HOME_MUL;
            end
         end
         S_HOME_MUL:  state_in = S_HOME_ACC;
         S_HOME_ACC:  state_in = dig_last ? S_PROBE_RD : S_HOME_MUL;
         S_PROBE_RD:  state_in = S_PROBE_CMP;
         S_PROBE_CMP: state_in = resolved ? S_RESP : S_PROBE_RD;
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      dctl       = '0;
      tctl       = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            dctl.load  = req_tvalid;
         end
         S_HOME_MUL:  dctl.mul = 1'b1;
         S_HOME_ACC:  dctl.acc = 1'b1;
         S_PROBE_RD:  tctl.rd  = 1'b1;
         S_PROBE_CMP: tctl.wr  = hit_empty && !cmd_ff;
         S_RESP:      rsp_tvalid = 1'b1;
         default: begin
            dctl = '0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      slot_in   = slot_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      rslot_in  = rslot_ff;
      if (state_ff == S_IDLE && req_acc) begin
         cmd_in    = req_tuser[0];
         key_in    = req_tdata;
         status_in = ST_ZERO;
         rslot_in  = '0;
      end
      if (state_ff == S_HOME_ACC && dig_last) begin
         slot_in = home;
         cnt_in  = '0;
      end
      if (state_ff == S_PROBE_CMP) begin
         if (hit_empty) begin
            status_in = cmd_ff ? ST_NOTFOUND : ST_INSERTED;
            rslot_in  = cmd_ff ? '0 : slot_ff;
         end else if (hit_key) begin
            status_in = cmd_ff ? ST_FOUND : ST_PRESENT;
            rslot_in  = slot_ff;
         end else if (cnt_ff == LastSlot) begin
            status_in = cmd_ff ? ST_NOTFOUND : ST_FULL;
            rslot_in  = '0;
         end else begin
            slot_in = (slot_ff == LastSlot) ? '0 : slot_ff + 1'b1;
            cnt_in  = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      slot_ff   <= slot_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      rslot_ff  <= rslot_in;
   end

   assign rslot_ext = {4'd0, rslot_ff};
   assign rsp_tdata = {4'd0, rslot_ext[3:0]};
   assign rsp_tuser = status_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while result pending");

   a_zero_key: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata == '0)
      |=> (rsp_tvalid && rsp_tuser == ST_ZERO && rsp_tdata == '0))
      else $error("zero key not rejected");

   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_NOTFOUND || rsp_tuser == ST_FULL ||
                      rsp_tuser == ST_ZERO)) |-> (rsp_tdata == '0))
      else $error("slot nonzero on miss");

   a_write_insert: assert property (@(posedge clock) disable iff (reset)
      tctl.wr |-> (!cmd_ff && key_ff != '0 && state_ff == S_PROBE_CMP))
      else $error("table write outside insert");

endmodule

[design/dslp_digit_unit.sv]
// Iterative digit-sum unit: each base-TABLE_SIZE digit takes a multiply step, then an accumulate step.
// Quotient by reciprocal multiply, running sum kept mod TABLE_SIZE.
// Depends on dslp_pkg.
module dslp_digit_unit
   import dslp_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF,
   parameter int SlotW      = $clog2(TABLE_SIZE)
) (
   input  logic             clock,
   input  dctl_type         ctl,
   input  logic [KEY_W-1:0] mag,
   output logic             last,
   output logic [SlotW-1:0] home
);

   localparam int          Shift   = KEY_W + SlotW;
   localparam logic [63:0] Pow     = 64'd1 << Shift;
   localparam logic [63:0] Recip64 = (Pow + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
   localparam logic [KEY_W:0] Recip = Recip64[KEY_W:0];
   localparam int          ProdW   = 2 * KEY_W + 1;

   logic [KEY_W-1:0] mag_ff, mag_in;
   logic [SlotW-1:0] sum_ff, sum_in;
   logic [ProdW-1:0] prod_ff;
   logic [KEY_W-1:0] quot;
   logic [KEY_W-1:0] rem_full;
   logic [SlotW:0]   sum_wide;

   always_comb begin
      quot     = KEY_W'(prod_ff >> Shift);
      rem_full = mag_ff - KEY_W'(quot * KEY_W'(TABLE_SIZE));
      sum_wide = {1'b0, sum_ff} + {1'b0, rem_full[SlotW-1:0]};
      if (sum_wide >= (SlotW+1)'(TABLE_SIZE)) begin
         sum_wide = sum_wide - (SlotW+1)'(TABLE_SIZE);
      end
      sum_in = sum_wide[SlotW-1:0];
      mag_in = quot;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         mag_ff <= mag;
         sum_ff <= '0;
      end else if (ctl.acc) begin
         mag_ff <= mag_in;
         sum_ff <= sum_in;
      end
      if (ctl.mul) begin
         prod_ff <= ProdW'(mag_ff) * ProdW'(Recip);
      end
   end

   assign last = (quot == '0);
   assign home = sum_in;

endmodule

[design/dslp_table.sv]
// Key store: TABLE_SIZE words, one port, registered read.
// Per-entry valid bits cleared by reset; an invalid entry reads as zero.
// Depends on dslp_pkg.
module dslp_table
   import dslp_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF,
   parameter int SlotW      = $clog2(TABLE_SIZE)
) (
   input  logic             clock,
   input  logic             reset,
   input  tctl_type         ctl,
   input  logic [SlotW-1:0] addr,
   input  logic [KEY_W-1:0] wr_data,
   output logic [KEY_W-1:0] rd_data
);

   logic [KEY_W-1:0]      mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] valid_ff;
   logic [KEY_W-1:0]      rd_data_ff;
   logic                  rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd) begin
         rd_data_ff <= mem[addr];
         rd_vld_ff  <= valid_ff[addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

[verif/tb_digit_sum_linear_probe_table_top.sv]
`timescale 1ns / 100ps
// Testbench for digit_sum_linear_probe_table_top: directed rows, then random insert/search words,
// each result checked against its typed row or an in-bench shadow of the key table.
// Depends on dslp_pkg and the design files.
module tb_digit_sum_linear_probe_table_top;
   import dslp_pkg::*;

   localparam int TSIZE       = TABLE_SIZE_DEF;
   localparam int N_RANDOM    = 650;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLDOFF_LEN = 400;
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef struct packed {
      status_type status;
      logic [3:0] slot;
   } rsp_word_type;

   typedef struct {
      logic        cmd;
      logic [31:0] key;
      logic        typed;
      status_type  status;
      logic [3:0]  slot;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] key
   logic [0:0]  req_tuser = '0;   // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [3:0] slot, [7:4] zero
   logic [2:0]  rsp_tuser;        // [2:0] status

   logic [31:0]  shadow_keys [TSIZE];
   rsp_word_type pending_rsp [$];
   int           err_cnt = 0;
   int           words_taken = 0;
   int           cycle_cnt = 0;
   logic         idle_on = 1'b1;

   // typed rows: empty table, zero key, key 1 insert/repeat/hit, full table; the rest come from the shadow table
   dir_row_type dir_rows [23] = '{
      '{CMD_SEARCH, 32'd1,          1'b1, ST_NOTFOUND, 4'd0},
      '{CMD_INSERT, 32'd0,          1'b1, ST_ZERO,     4'd0},
      '{CMD_SEARCH, 32'd0,          1'b1, ST_ZERO,     4'd0},
      '{CMD_INSERT, 32'd1,          1'b1, ST_INSERTED, 4'd1},
      '{CMD_INSERT, 32'd1,          1'b1, ST_PRESENT,  4'd1},
      '{CMD_SEARCH, 32'd1,          1'b1, ST_FOUND,    4'd1},
      '{CMD_INSERT, 32'd10,         1'b0, ST_INSERTED, 4'd0},
      '{CMD_INSERT, 32'd19,         1'b0, ST_INSERTED, 4'd0},
      '{CMD_INSERT, 32'hFFFF_FFFF,  1'b0, ST_INSERTED, 4'd0},
      '{CMD_INSERT, 32'h8000_0000,  1'b0, ST_INSERTED, 4'd0},
      '{CMD_INSERT, 32'h7FFF_FFFF,  1'b0, ST_INSERTED, 4'd0},
      '{CMD_INSERT, 32'hFFFF_FFFF,  1'b0, ST_INSERTED, 4'd0},
      '{CMD_SEARCH, 32'h8000_0000,  1'b0, ST_INSERTED, 4'd0},
      '{CMD_SEARCH, 32'd100,        1'b0, ST_INSERTED, 4'd0},
      '{CMD_SEARCH, 32'hFFFF_FFF6,  1'b0, ST_INSERTED, 4'd0},
      '{CMD_INSERT, 32'd28,         1'b0, ST_INSERTED, 4'd0},
      '{CMD_SEARCH, 32'd10,         1'b0, ST_INSERTED, 4'd0},
      '{CMD_SEARCH, 32'h7FFF_FFFF,  1'b0, ST_INSERTED, 4'd0},
      '{CMD_INSERT, 32'd9,          1'b0, ST_INSERTED, 4'd0},
      '{CMD_INSERT, 32'd18,         1'b0, ST_INSERTED, 4'd0},
      '{CMD_INSERT, 32'd99,         1'b0, ST_INSERTED, 4'd0},
      '{CMD_INSERT, 32'd2,          1'b1, ST_FULL,     4'd0},
      '{CMD_SEARCH, 32'd2,          1'b1, ST_NOTFOUND, 4'd0}
   };

   digit_sum_linear_probe_table_top #(.TABLE_SIZE(TSIZE)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // home slot: digit sum of |key| in base TSIZE, mod TSIZE
   function automatic int digit_home(input logic [31:0] key);
      logic [31:0] mag;
      int unsigned total;
      mag   = key[31] ? -key : key;
      total = 0;
      while (mag != 0) begin
         total += mag % TSIZE;
         mag    = mag / TSIZE;
      end
      return total % TSIZE;
   endfunction

   function automatic rsp_word_type table_lookup(input logic cmd, input logic [31:0] key);
      rsp_word_type res;
      int home;
      int idx;
      int pos;
      logic hit;
      res.status = ST_ZERO;
      res.slot   = '0;
      hit        = 1'b0;
      pos        = 0;
      if (key != 0) begin
         home = digit_home(key);
         for (idx = 0; idx < TSIZE && !hit; idx++) begin
            pos = (home + idx) % TSIZE;
            if (shadow_keys[pos] == 0 || shadow_keys[pos] == key) hit = 1'b1;
         end
         if (!hit) begin
            res.status = (cmd == CMD_SEARCH) ? ST_NOTFOUND : ST_FULL;
         end else if (cmd == CMD_SEARCH) begin
            if (shadow_keys[pos] != 0) begin
               res.status = ST_FOUND;
               res.slot   = pos[3:0];
            end else begin
               res.status = ST_NOTFOUND;
            end
         end else begin
            if (shadow_keys[pos] != 0) begin
               res.status = ST_PRESENT;
            end else begin
               shadow_keys[pos] = key;
               res.status = ST_INSERTED;
            end
            res.slot = pos[3:0];
         end
      end
      return res;
   endfunction

   // mostly keys already held or close to them, so hits, misses and long probes all occur
   function automatic logic [31:0] draw_key();
      int pick;
      logic [31:0] held;
      pick = $urandom_range(99);
      held = shadow_keys[$urandom_range(TSIZE - 1)];
      if (held == 0) held = $urandom();
      if (pick < 40) return held;
      if (pick < 55) return held + 32'($urandom_range(6)) - 32'd3;
      if (pick < 70) return 32'($urandom_range(200)) - 32'd100;
      if (pick < 92) return $urandom();
      if (pick < 96) return 32'd0;
      case ($urandom_range(3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         default: return 32'd1;
      endcase
   endfunction

   task automatic send_word(input logic cmd, input logic [31:0] key, input logic typed,
                            input status_type status, input logic [3:0] slot);
      rsp_word_type want;
      while (idle_on && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= key;
      req_tuser[0] <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = table_lookup(cmd, key);
      if (typed) begin
         want.status = status;
         want.slot   = slot;
      end
      pending_rsp.push_back(want);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_taken++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected result word: status %0d slot %0d", rsp_tuser, rsp_tdata[3:0]);
            err_cnt++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser != want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               err_cnt++;
            end
            if (rsp_tdata[3:0] != want.slot) begin
               $error("slot: expected %0d, actual %0d", want.slot, rsp_tdata[3:0]);
               err_cnt++;
            end
            if (rsp_tdata[7:4] != 4'd0) begin
               $error("tdata pad: expected 0, actual %0d", rsp_tdata[7:4]);
               err_cnt++;
            end
         end
      end
   end

   // receiver: random stalls plus one long hold-off once traffic is flowing
   initial begin : rsp_side
      int holdoff_left;
      logic holdoff_done;
      holdoff_left = 0;
      holdoff_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!holdoff_done && words_taken >= 120) begin
            holdoff_left = HOLDOFF_LEN;
            holdoff_done = 1'b1;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= idle_on ? ($urandom_range(99) >= 29) : 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_cnt < CYCLE_LIMIT) @(posedge clock) cycle_cnt++;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int n;
      logic cmd;
      logic [31:0] key;
      foreach (shadow_keys[i]) shadow_keys[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i])
         send_word(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed,
                   dir_rows[i].status, dir_rows[i].slot);

      for (n = 0; n < N_RANDOM; n++) begin
         if (n == 300) begin
            req_tvalid <= 1'b0;
            while (pending_rsp.size() != 0) @(negedge clock);
         end
         idle_on = !(n >= 450 && n < 550);
         cmd = 1'($urandom_range(1));
         key = draw_key();
         send_word(cmd, key, 1'b0, ST_INSERTED, 4'd0);
      end
      req_tvalid <= 1'b0;
      idle_on = 1'b1;

      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (err_cnt == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
